// ===== src/csa_pkg.sv =====
// Shared types and constants for the composite section accumulator.
`timescale 1ns / 1ps

package csa_pkg;

	localparam int AREA_W    = 48;
	localparam int CENT_W    = 32;
	localparam int MOM_W     = 64;
	localparam int WIDE_W    = 128;
	localparam int NUM_W     = 81;
	localparam int MUL_W     = 64;
	localparam int MUL_CHUNK = 16;
	localparam int DATA_W    = AREA_W + 3 * CENT_W + 3 * MOM_W;
	localparam int CENT_OFS  = AREA_W;
	localparam int MOM_OFS   = AREA_W + 3 * CENT_W;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_SUB   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_NPOS = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WACC,
		ST_WIN,
		ST_DIV,
		ST_TM,
		ST_TP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              start;
		op_t               op;
		logic [MUL_W-1:0]  mul_a;
		logic [MUL_W-1:0]  mul_b;
		logic [NUM_W-1:0]  num;
		logic [AREA_W-1:0] den;
	} arith_req_t;

	typedef struct packed {
		logic              done;
		logic [WIDE_W-1:0] res;
	} arith_rsp_t;

endpackage

// ===== src/csa_arith.sv =====
// Shared multi-cycle unit: 64x64 multiply in 16-bit chunks, restoring divide one bit a cycle.
`timescale 1ns / 1ps

module csa_arith import csa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  arith_req_t req,
	output arith_rsp_t rsp
);

	localparam int CNT_W     = $clog2(NUM_W);
	localparam int MUL_STEPS = MUL_W / MUL_CHUNK;

	logic              busy_q;
	logic              done_q;
	op_t               op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WIDE_W-1:0] prod_q;
	logic [MUL_W-1:0]  ma_q;
	logic [MUL_W-1:0]  mb_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [AREA_W-1:0] den_q;
	logic [AREA_W-1:0] rem_q;

	logic [MUL_W+MUL_CHUNK-1:0] pp;
	logic [AREA_W:0]            trial;
	logic                       ge;

	always_comb begin
		pp    = ma_q * mb_q[MUL_W-1 -: MUL_CHUNK];
		trial = {rem_q, num_q[NUM_W-1]};
		ge    = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == OP_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// chunks of b taken from the top, so the running product shifts by a constant
	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q   <= req.mul_a;
			mb_q   <= req.mul_b;
			prod_q <= '0;
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				prod_q <= {prod_q[WIDE_W-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}} + WIDE_W'(pp);
				mb_q   <= mb_q << MUL_CHUNK;
			end else begin
				rem_q <= ge ? AREA_W'(trial - {1'b0, den_q}) : trial[AREA_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], ge};
				num_q <= num_q << 1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = (op_q == OP_MUL) ? prod_q : WIDE_W'(quo_q);

endmodule

// ===== src/composite_section_accumulator_unit.sv =====
// Top level: composite section accumulator with its sequencer and committed state.
//
// channel | dir | words                      | tdata / tuser
// s_      | in  | one section or command     | area, cent_x/y/z, mom_xx/yy/xy / cmd
// m_      | out | composite after each word  | comp_area, comp_x/y/z, comp_xx/yy/xy / status
//
// Clear, unused command and area errors go from idle straight to the result step.
// Add/subtract: per coordinate two multiplies and a divide, then six pairs of multiplies for
// the moment terms, all on the shared multiply/divide unit; a centroid that does not fit ends it early.
// s_tready is high only while idle; a result waits in the output register without
// holding up the next word. Reset clears the composite to zero.
`timescale 1ns / 1ps

module composite_section_accumulator_unit import csa_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,  // area, cent_x, cent_y, cent_z, mom_xx, mom_yy, mom_xy
	input  logic [1:0]        s_tuser,  // cmd
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,  // comp_area, comp_x, comp_y, comp_z, comp_xx, comp_yy, comp_xy
	output logic [1:0]        m_tuser   // status
);

	localparam logic [1:0] K_LAST = 2'd2;
	localparam logic [2:0] J_LAST = 3'd5;

	state_t state_q, state_d;
	logic   go_q, go_d;
	logic [1:0] k_q, k_d;
	logic [2:0] j_q, j_d;

	logic [AREA_W-1:0]       acc_area_q;
	logic signed [CENT_W-1:0] acc_c_q [3];
	logic signed [MOM_W-1:0]  acc_m_q [3];

	logic [AREA_W-1:0]        a_q;
	logic [AREA_W-1:0]        na_q;
	logic signed [CENT_W-1:0] in_c_q [3];
	logic                     sub_q;
	logic [1:0]               stat_q;
	logic                     clr_q, calc_q, ok_q;
	logic signed [WIDE_W-1:0] wacc_q, num_q;
	logic signed [CENT_W-1:0] cres_q [3];
	logic [MUL_W-1:0]         m_q;
	logic signed [WIDE_W-1:0] rsum_q [3];

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [1:0]        out_stat_q;

	arith_req_t arq;
	arith_rsp_t ars;

	csa_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (arq),
		.rsp    (ars)
	);

	function automatic logic [CENT_W:0] mag33(input logic signed [CENT_W:0] v);
		return v[CENT_W] ? (CENT_W + 1)'(-v) : (CENT_W + 1)'(v);
	endfunction

	function automatic logic fits(input logic [WIDE_W-1:0] v, input int w);
		logic [WIDE_W-1:0] top;
		top = v >> (w - 1);
		return (top == '0) || (top == (WIDE_W'({WIDE_W{1'b1}}) >> (w - 1)));
	endfunction

	// input word
	logic [1:0]               in_cmd;
	logic [AREA_W-1:0]        in_area;
	logic signed [CENT_W-1:0] in_c [3];
	logic signed [MOM_W-1:0]  in_m [3];
	logic                     acc_in;
	logic [AREA_W:0]          sum49;
	logic [1:0]               area_stat;
	logic                     start_calc;

	always_comb begin
		in_cmd  = s_tuser;
		in_area = s_tdata[AREA_W-1:0];
		for (int i = 0; i < 3; i++) begin
			in_c[i] = s_tdata[CENT_OFS + CENT_W * i +: CENT_W];
			in_m[i] = s_tdata[MOM_OFS + MOM_W * i +: MOM_W];
		end
		sum49     = {1'b0, acc_area_q} + {1'b0, in_area};
		area_stat = STAT_OK;
		if (in_cmd == CMD_SUB) begin
			if (in_area >= acc_area_q) area_stat = STAT_NPOS;
		end else if (in_cmd == CMD_ADD) begin
			if (sum49 == '0) area_stat = STAT_NPOS;
			else if (sum49[AREA_W]) area_stat = STAT_OVF;
		end
		start_calc = ((in_cmd == CMD_ADD) || (in_cmd == CMD_SUB)) && (area_stat == STAT_OK);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;

	// deltas to the new centroid
	logic signed [CENT_W:0] dx, dy, ex, ey, d1, d2;
	logic                   tneg;
	logic [WIDE_W-1:0]      tsh;
	logic signed [WIDE_W-1:0] tval, radd, wval, nmag;
	logic [NUM_W:0]         cv;
	logic                   fit32;

	always_comb begin
		dx = {cres_q[0][CENT_W-1], cres_q[0]} - {acc_c_q[0][CENT_W-1], acc_c_q[0]};
		dy = {cres_q[1][CENT_W-1], cres_q[1]} - {acc_c_q[1][CENT_W-1], acc_c_q[1]};
		ex = {cres_q[0][CENT_W-1], cres_q[0]} - {in_c_q[0][CENT_W-1], in_c_q[0]};
		ey = {cres_q[1][CENT_W-1], cres_q[1]} - {in_c_q[1][CENT_W-1], in_c_q[1]};
		case (j_q)
			3'd0:    begin d1 = dy; d2 = dy; end
			3'd1:    begin d1 = ey; d2 = ey; end
			3'd2:    begin d1 = dx; d2 = dx; end
			3'd3:    begin d1 = ex; d2 = ex; end
			3'd4:    begin d1 = dx; d2 = dy; end
			default: begin d1 = ex; d2 = ey; end
		endcase
		tneg = d1[CENT_W] ^ d2[CENT_W];
		tsh  = ars.res >> (2 * FRAC_BITS);
		tval = tneg ? -$signed(tsh) : $signed(tsh);
		radd = (j_q[0] && sub_q) ? -tval : tval;
		if (state_q == ST_WACC) wval = acc_c_q[k_q][CENT_W-1] ? -$signed(ars.res) : $signed(ars.res);
		else                    wval = in_c_q[k_q][CENT_W-1] ? -$signed(ars.res) : $signed(ars.res);
		nmag  = num_q[WIDE_W-1] ? -num_q : num_q;
		cv    = num_q[WIDE_W-1] ? -{1'b0, ars.res[NUM_W-1:0]} : {1'b0, ars.res[NUM_W-1:0]};
		fit32 = (&cv[NUM_W:CENT_W-1]) || !(|cv[NUM_W:CENT_W-1]);
	end

	// result of the item
	logic                     fin_commit, fin_take;
	logic [1:0]               fin_stat;
	logic [AREA_W-1:0]        nxt_area;
	logic signed [CENT_W-1:0] nxt_c [3];
	logic signed [MOM_W-1:0]  nxt_m [3];

	always_comb begin
		fin_commit = calc_q && ok_q && fits(rsum_q[0], MOM_W) && fits(rsum_q[1], MOM_W)
			&& fits(rsum_q[2], MOM_W);
		fin_stat   = (calc_q && !fin_commit) ? STAT_OVF : stat_q;
		fin_take   = (state_q == ST_FIN) && (!out_valid_q || m_tready);
		nxt_area   = acc_area_q;
		for (int i = 0; i < 3; i++) begin
			nxt_c[i] = acc_c_q[i];
			nxt_m[i] = acc_m_q[i];
		end
		if (clr_q) begin
			nxt_area = '0;
			for (int i = 0; i < 3; i++) begin
				nxt_c[i] = '0;
				nxt_m[i] = '0;
			end
		end else if (fin_commit) begin
			nxt_area = na_q;
			for (int i = 0; i < 3; i++) begin
				nxt_c[i] = cres_q[i];
				nxt_m[i] = rsum_q[i][MOM_W-1:0];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		go_d    = 1'b0;
		k_d     = k_q;
		j_d     = j_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (start_calc) begin
						state_d = ST_WACC;
						go_d    = 1'b1;
						k_d     = '0;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_WACC: begin
				if (ars.done) begin
					state_d = ST_WIN;
					go_d    = 1'b1;
				end
			end
			ST_WIN: begin
				if (ars.done) begin
					state_d = ST_DIV;
					go_d    = 1'b1;
				end
			end
			ST_DIV: begin
				if (ars.done) begin
					if (!fit32) begin
						state_d = ST_FIN;
					end else if (k_q == K_LAST) begin
						state_d = ST_TM;
						go_d    = 1'b1;
						j_d     = '0;
					end else begin
						state_d = ST_WACC;
						go_d    = 1'b1;
						k_d     = k_q + 1'b1;
					end
				end
			end
			ST_TM: begin
				if (ars.done) begin
					state_d = ST_TP;
					go_d    = 1'b1;
				end
			end
			ST_TP: begin
				if (ars.done) begin
					if (j_q == J_LAST) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_TM;
						go_d    = 1'b1;
						j_d     = j_q + 1'b1;
					end
				end
			end
			ST_FIN: begin
				if (fin_take) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// operands for the shared unit
	always_comb begin
		arq       = '0;
		arq.start = go_q;
		arq.den   = na_q;
		arq.num   = nmag[NUM_W-1:0];
		case (state_q)
			ST_WACC: begin
				arq.op    = OP_MUL;
				arq.mul_a = MUL_W'(mag33({acc_c_q[k_q][CENT_W-1], acc_c_q[k_q]}));
				arq.mul_b = MUL_W'(acc_area_q);
			end
			ST_WIN: begin
				arq.op    = OP_MUL;
				arq.mul_a = MUL_W'(mag33({in_c_q[k_q][CENT_W-1], in_c_q[k_q]}));
				arq.mul_b = MUL_W'(a_q);
			end
			ST_DIV: begin
				arq.op = OP_DIV;
			end
			ST_TM: begin
				// product of magnitudes wraps at 64 bits
				arq.op    = OP_MUL;
				arq.mul_a = MUL_W'(mag33(d1));
				arq.mul_b = MUL_W'(mag33(d2));
			end
			ST_TP: begin
				arq.op    = OP_MUL;
				arq.mul_a = j_q[0] ? MUL_W'(a_q) : MUL_W'(acc_area_q);
				arq.mul_b = m_q;
			end
			default: arq.op = OP_MUL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			k_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
			stat_q      <= STAT_OK;
			clr_q       <= 1'b0;
			calc_q      <= 1'b0;
			ok_q        <= 1'b0;
			acc_area_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				acc_c_q[i] <= '0;
				acc_m_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
			k_q     <= k_d;
			j_q     <= j_d;
			if (acc_in) begin
				stat_q <= area_stat;
				clr_q  <= (in_cmd == CMD_CLEAR);
				calc_q <= start_calc;
				ok_q   <= 1'b1;
			end else if (state_q == ST_DIV && ars.done && !fit32) begin
				ok_q <= 1'b0;
			end
			if (fin_take) begin
				out_valid_q <= 1'b1;
				acc_area_q  <= nxt_area;
				for (int i = 0; i < 3; i++) begin
					acc_c_q[i] <= nxt_c[i];
					acc_m_q[i] <= nxt_m[i];
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			a_q   <= in_area;
			na_q  <= (in_cmd == CMD_SUB) ? AREA_W'(acc_area_q - in_area) : sum49[AREA_W-1:0];
			sub_q <= (in_cmd == CMD_SUB);
			for (int i = 0; i < 3; i++) begin
				in_c_q[i] <= in_c[i];
				if (in_cmd == CMD_SUB)
					rsum_q[i] <= WIDE_W'(acc_m_q[i]) - WIDE_W'(in_m[i]);
				else
					rsum_q[i] <= WIDE_W'(acc_m_q[i]) + WIDE_W'(in_m[i]);
			end
		end
		if (ars.done) begin
			case (state_q)
				ST_WACC: wacc_q <= wval;
				ST_WIN:  num_q  <= sub_q ? (wacc_q - wval) : (wacc_q + wval);
				ST_DIV:  cres_q[k_q] <= cv[CENT_W-1:0];
				ST_TM:   m_q    <= ars.res[MUL_W-1:0];
				ST_TP:   rsum_q[j_q[2:1]] <= rsum_q[j_q[2:1]] + radd;
				default: ;
			endcase
		end
		if (fin_take) begin
			out_data_q <= {nxt_m[2], nxt_m[1], nxt_m[0], nxt_c[2], nxt_c[1], nxt_c[0], nxt_area};
			out_stat_q <= fin_stat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_stat_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		arq.start |-> (state_q != ST_IDLE) && (state_q != ST_FIN))
		else $error("shared unit started outside a compute step");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> (state_q != ST_IDLE))
		else $error("accepted word did not start a sequence");

	a_done_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		ars.done |-> (state_q != ST_IDLE) && (state_q != ST_FIN))
		else $error("shared unit finished with no step waiting");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the composite section accumulator unit.
`timescale 1ns / 1ps

module testbench;
	import csa_pkg::*;

	localparam int FRAC       = 16;
	localparam int LIMIT      = 5_000_000;
	localparam int LONG_HOLD  = 3000;
	localparam int N_RANDOM   = 1330;

	// selector value with no operation behind it
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [47:0]        area;
		logic signed [31:0] cx, cy, cz;
		logic signed [63:0] ixx, iyy, ixy;
	} section_t;

	typedef struct packed {
		logic [47:0]        area;
		logic signed [31:0] x, y, z;
		logic signed [63:0] xx, yy, xy;
		logic [1:0]         status;
	} composite_t;

	typedef logic signed [127:0] wide_t;

	// Composite properties predictor and queue of expected composites
	class section_board;
		logic [47:0]        c_area;
		logic signed [31:0] c_x, c_y, c_z;
		logic signed [63:0] c_xx, c_yy, c_xy;
		composite_t         want_q[$];
		int                 errors;

		function new();
			wipe();
			errors = 0;
		endfunction

		function void wipe();
			c_area = '0; c_x = '0; c_y = '0; c_z = '0;
			c_xx = '0; c_yy = '0; c_xy = '0;
		endfunction

		function wide_t weigh(logic signed [31:0] c, logic [47:0] a);
			return wide_t'(c) * $signed({80'd0, a});
		endfunction

		// a*d1*d2 with 2F fraction bits dropped, truncated toward zero; the
		// magnitude product of the offsets wraps at 64 bits
		function wide_t shift_term(logic [47:0] a, wide_t d1, wide_t d2);
			logic [127:0] m1, m2, p;
			logic [63:0]  m;
			m1 = d1 < 0 ? -d1 : d1;
			m2 = d2 < 0 ? -d2 : d2;
			m = m1[63:0] * m2[63:0];
			p = {80'd0, a} * {64'd0, m};
			p = p >> (2 * FRAC);
			return ((d1 < 0) != (d2 < 0)) ? -$signed(p) : $signed(p);
		endfunction

		function wide_t mix(bit sub, wide_t p, wide_t q);
			return sub ? p - q : p + q;
		endfunction

		function bit fits(wide_t v, int w);
			wide_t t;
			t = (v <<< (128 - w)) >>> (128 - w);
			return t == v;
		endfunction

		function composite_t fold(section_t s);
			composite_t r;
			logic [48:0] na;
			wide_t cen [3];
			wide_t dx, dy, ex, ey, rxx, ryy, rxy, den;
			logic signed [31:0] accc [3], inc [3];
			bit sub, ok;
			sub = (s.cmd == CMD_SUB);
			r.status = STAT_OK;
			na = '0;
			if (s.cmd == CMD_CLEAR) begin
				wipe();
			end else if (s.cmd == CMD_ADD || s.cmd == CMD_SUB) begin
				if (!sub) begin
					na = {1'b0, c_area} + {1'b0, s.area};
					if (na == 0) r.status = STAT_NPOS;
					else if (na[48]) r.status = STAT_OVF;
				end else begin
					if (s.area >= c_area) r.status = STAT_NPOS;
					else na = {1'b0, c_area - s.area};
				end
				if (r.status == STAT_OK) begin
					accc = '{c_x, c_y, c_z};
					inc = '{s.cx, s.cy, s.cz};
					den = $signed({80'd0, na[47:0]});
					ok = 1'b1;
					for (int k = 0; k < 3; k++) begin
						cen[k] = mix(sub, weigh(accc[k], c_area), weigh(inc[k], s.area)) / den;
						if (!fits(cen[k], 32)) ok = 1'b0;
					end
					if (ok) begin
						dx = cen[0] - wide_t'(c_x);
						dy = cen[1] - wide_t'(c_y);
						ex = cen[0] - wide_t'(s.cx);
						ey = cen[1] - wide_t'(s.cy);
						rxx = mix(sub, wide_t'(c_xx) + shift_term(c_area, dy, dy),
							wide_t'(s.ixx) + shift_term(s.area, ey, ey));
						ryy = mix(sub, wide_t'(c_yy) + shift_term(c_area, dx, dx),
							wide_t'(s.iyy) + shift_term(s.area, ex, ex));
						rxy = mix(sub, wide_t'(c_xy) + shift_term(c_area, dx, dy),
							wide_t'(s.ixy) + shift_term(s.area, ex, ey));
						ok = fits(rxx, 64) && fits(ryy, 64) && fits(rxy, 64);
					end
					if (!ok) begin
						r.status = STAT_OVF;
					end else begin
						c_area = na[47:0];
						c_x = cen[0][31:0]; c_y = cen[1][31:0]; c_z = cen[2][31:0];
						c_xx = rxx[63:0]; c_yy = ryy[63:0]; c_xy = rxy[63:0];
					end
				end
			end
			r.area = c_area; r.x = c_x; r.y = c_y; r.z = c_z;
			r.xx = c_xx; r.yy = c_yy; r.xy = c_xy;
			return r;
		endfunction

		function void note_section(section_t s);
			want_q.push_back(fold(s));
		endfunction

		task report(string field, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
			errors++;
		endtask

		task check_result(logic [DATA_W-1:0] data, logic [1:0] user);
			composite_t g, w;
			g = {data[47:0], data[79:48], data[111:80], data[143:112],
				data[207:144], data[271:208], data[335:272], user};
			if (want_q.size() == 0) begin
				report("unexpected word", data[63:0], '0);
				return;
			end
			w = want_q.pop_front();
			if (g.area !== w.area)     report("comp_area", g.area, w.area);
			if (g.x !== w.x)           report("comp_x", g.x, w.x);
			if (g.y !== w.y)           report("comp_y", g.y, w.y);
			if (g.z !== w.z)           report("comp_z", g.z, w.z);
			if (g.xx !== w.xx)         report("comp_xx", g.xx, w.xx);
			if (g.yy !== w.yy)         report("comp_yy", g.yy, w.yy);
			if (g.xy !== w.xy)         report("comp_xy", g.xy, w.xy);
			if (g.status !== w.status) report("status", g.status, w.status);
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;   // area, cent_x, cent_y, cent_z, mom_xx, mom_yy, mom_xy
	logic [1:0]        s_tuser = '0;   // cmd
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;        // comp_area, comp_x/y/z, comp_xx/yy/xy
	logic [1:0]        m_tuser;        // status

	section_board sb = new();
	bit           calm;
	bit           hold_req;
	int           cycles;

	composite_section_accumulator_unit #(.FRAC_BITS(FRAC)) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	// result side: random stalls, one long hold-off on request
	initial begin
		int g;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				g = pick_gap();
				if (g > 0) begin
					m_tready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic rest(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic push_section(section_t s);
		s_tvalid <= 1'b1;
		s_tuser <= s.cmd;
		s_tdata <= {s.ixy, s.iyy, s.ixx, s.cz, s.cy, s.cx, s.area};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_section(s);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic section_t mk(logic [1:0] cmd, logic [47:0] a, logic [31:0] x,
		logic [31:0] y, logic [31:0] z, logic [63:0] ixx, logic [63:0] iyy, logic [63:0] ixy);
		section_t s;
		s = '{cmd, a, x, y, z, ixx, iyy, ixy};
		return s;
	endfunction

	function automatic section_t random_section();
		section_t s;
		int r;
		logic [63:0] w;
		r = $urandom_range(0, 99);
		s = mk(CMD_ADD, 48'(rnd64()), $urandom, $urandom, $urandom, rnd64(), rnd64(), rnd64());
		if (r < 4) begin
			s.cmd = CMD_CLEAR;
		end else if (r < 6) begin
			s.cmd = CMD_SPARE;
		end else if (r < 14) begin
			s.cmd = $urandom_range(0, 1) ? CMD_SUB : CMD_ADD;
		end else begin
			// well-formed section with modest magnitudes
			s.cx = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
			s.cy = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
			s.cz = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
			s.ixx = $signed(rnd64() >> 24) - (64'sd1 <<< 38);
			s.iyy = $signed(rnd64() >> 24) - (64'sd1 <<< 38);
			s.ixy = $signed(rnd64() >> 24) - (64'sd1 <<< 38);
			if (r < 40 && sb.c_area > 1) begin
				s.cmd = CMD_SUB;
				w = rnd64();
				s.area = 48'(w % sb.c_area);
			end else begin
				s.area = $urandom_range(1, 1 << 26);
			end
		end
		return s;
	endfunction

	localparam logic [47:0] AMAX = '1;
	localparam logic [31:0] CMAX = 32'h7fff_ffff;
	localparam logic [31:0] CMIN = 32'h8000_0000;
	localparam logic [63:0] MMAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MMIN = 64'h8000_0000_0000_0000;

	initial begin
		section_t d [$];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: errors, unused command, field extremes, overflows, clear
		d.push_back(mk(CMD_ADD, 0, 0, 0, 0, 0, 0, 0));
		d.push_back(mk(CMD_SPARE, AMAX, CMAX, CMIN, CMAX, MMAX, MMIN, MMAX));
		d.push_back(mk(CMD_SUB, 0, 0, 0, 0, 0, 0, 0));
		d.push_back(mk(CMD_ADD, 1 << 16, CMAX, CMIN, 0, 1000, 2000, -3000));
		d.push_back(mk(CMD_ADD, 1 << 16, CMIN, CMAX, 1 << 16, 5, 7, 9));
		d.push_back(mk(CMD_SUB, 1 << 17, 0, 0, 0, 0, 0, 0));
		d.push_back(mk(CMD_SUB, 1 << 20, 0, 0, 0, 0, 0, 0));
		d.push_back(mk(CMD_SUB, 1 << 16, CMAX, CMIN, 0, 1000, 2000, -3000));
		d.push_back(mk(CMD_ADD, AMAX, 0, 0, 0, 0, 0, 0));
		d.push_back(mk(CMD_ADD, 3 << 16, 12345, -777, 99, MMAX, MMAX, MMIN));
		d.push_back(mk(CMD_ADD, 1 << 16, 0, 0, 0, MMAX, 0, 0));
		d.push_back(mk(CMD_ADD, 1, CMAX, CMAX, CMAX, 0, 0, 0));
		d.push_back(mk(CMD_CLEAR, AMAX, CMIN, CMIN, CMIN, MMIN, MMIN, MMIN));
		d.push_back(mk(CMD_ADD, AMAX, CMIN, CMAX, CMIN, 0, 0, 0));
		d.push_back(mk(CMD_ADD, 1, 0, 0, 0, 0, 0, 0));
		d.push_back(mk(CMD_SUB, AMAX - 1, CMAX, CMAX, CMAX, 0, 0, 0));
		d.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		d.push_back(mk(CMD_ADD, 10 << 16, 1 << 16, 2 << 16, -3 << 16, 1 << 20, 1 << 20, 0));
		d.push_back(mk(CMD_ADD, 5 << 16, -4 << 16, 1 << 16, 7 << 16, 1 << 18, 1 << 19, -100));
		d.push_back(mk(CMD_SUB, 2 << 16, 3 << 16, -2 << 16, 0, 1 << 10, 1 << 11, 55));
		d.push_back(mk(CMD_SPARE, 0, 0, 0, 0, 0, 0, 0));
		d.push_back(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		foreach (d[i]) begin
			rest(pick_gap());
			push_section(d[i]);
		end

		// random: phases alternate between random gaps and full rate
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 150 == 0) calm = !calm;
			if (i == 300) hold_req = 1'b1;
			if (i == 600) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.want_q.size() != 0) @(posedge clk);
			end
			if (i < 300 || i > 310) rest(pick_gap());
			push_section(random_section());
		end
		s_tvalid <= 1'b0;

		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (sb.errors == 0 && sb.want_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
